// File: src/tlvf_pkg.sv
// Package for the TLV record finder: beat types, status codes, header phase encoding.
// No dependencies; every other file of the block imports it.

package tlvf_pkg;

  localparam int HdrBytes = 2 + 2;
  localparam int ByteBits = 8;
  localparam int LenBits  = 2 * ByteBits;
  localparam int StatBits = 2;

  localparam logic [StatBits-1:0] ST_VALUE    = 2'd0;
  localparam logic [StatBits-1:0] ST_EMPTY    = 2'd1;
  localparam logic [StatBits-1:0] ST_NOTFOUND = 2'd2;
  localparam logic [StatBits-1:0] ST_TRUNC    = 2'd3;

  typedef enum logic [HdrBytes:0] {
    PH_TYPE_LO = 5'b00001,
    PH_TYPE_HI = 5'b00010,
    PH_LEN_LO  = 5'b00100,
    PH_LEN_HI  = 5'b01000,
    PH_VALUE   = 5'b10000
  } phase_t;

  typedef struct packed {
    logic [ByteBits-1:0] data_byte;
    logic                end_of_message;
  } in_beat_t;

  typedef struct packed {
    logic [ByteBits-1:0] value_byte;
    logic [LenBits-1:0]  value_offset;
    logic [LenBits-1:0]  record_length;
    logic [StatBits-1:0] status;
    logic                is_last;
  } out_beat_t;

endpackage

// File: src/tlvf_ifs.sv
// Valid/ready channel interfaces for the TLV record finder: input, result and config.
// Depends on tlvf_pkg for field widths.

interface tlvf_in_if import tlvf_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [ByteBits-1:0] data_byte;
  logic                end_of_message;

  modport source (output valid, data_byte, end_of_message, input ready);
  modport sink   (input valid, data_byte, end_of_message, output ready);
endinterface

interface tlvf_out_if import tlvf_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [ByteBits-1:0] value_byte;
  logic [LenBits-1:0]  value_offset;
  logic [LenBits-1:0]  record_length;
  logic [StatBits-1:0] status;
  logic                is_last;

  modport source (output valid, value_byte, value_offset, record_length, status, is_last,
                  input ready);
  modport sink   (input valid, value_byte, value_offset, record_length, status, is_last,
                  output ready);
endinterface

interface tlvf_cfg_if import tlvf_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [LenBits-1:0] target_type;

  modport source (output valid, target_type, input ready);
  modport sink   (input valid, target_type, output ready);
endinterface

// File: src/tlvf_in_stage.sv
// Input register stage of the TLV record finder: holds one accepted input beat.
// Depends on tlvf_pkg.

module tlvf_in_stage import tlvf_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  in_beat_t in_beat,
  output logic     s1_valid,
  input  logic     s1_ready,
  output in_beat_t s1_beat
);

  logic     valid_r;
  in_beat_t beat_r;

  assign in_ready = !valid_r || s1_ready;
  assign s1_valid = valid_r;
  assign s1_beat  = beat_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      beat_r <= in_beat;
    end
  end

endmodule

// File: src/tlvf_parser.sv
// Record parser and result register of the TLV record finder.
// Walks headers and values one byte a beat; depends on tlvf_pkg.

module tlvf_parser import tlvf_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic [LenBits-1:0] target_type,
  input  logic               s1_valid,
  output logic               s1_ready,
  input  in_beat_t           s1_beat,
  output logic               out_valid,
  input  logic               out_ready,
  output out_beat_t          out_beat
);

  phase_t              phase_r, phase_nxt;
  logic [ByteBits-1:0] tlo_r, tlo_nxt;
  logic [LenBits-1:0]  len_r, len_nxt;
  logic [LenBits-1:0]  rem_r, rem_nxt;
  logic                match_r, match_nxt;
  logic                done_r, done_nxt;
  logic                out_valid_r;
  out_beat_t           out_r;

  logic                take;
  logic                fire;
  logic                res_v;
  logic                fin;
  out_beat_t           res;

  assign take      = !out_valid_r || out_ready;
  assign fire      = s1_valid && take;
  assign s1_ready  = take;
  assign out_valid = out_valid_r;
  assign out_beat  = out_r;

  always_comb begin
    logic [ByteBits-1:0] b;
    logic                eom;
    logic [LenBits-1:0]  len_full;
    logic [LenBits-1:0]  off;
    logic [LenBits-1:0]  rem_dec;

    b        = s1_beat.data_byte;
    eom      = s1_beat.end_of_message;
    len_full = {b, len_r[ByteBits-1:0]};
    off      = len_r - rem_r;
    rem_dec  = rem_r - {{(LenBits-1){1'b0}}, 1'b1};

    phase_nxt = phase_r;
    tlo_nxt   = tlo_r;
    len_nxt   = len_r;
    rem_nxt   = rem_r;
    match_nxt = match_r;
    done_nxt  = done_r;
    res_v     = 1'b0;
    fin       = 1'b0;
    res       = '0;

    if (!done_r) begin
      case (phase_r)
        PH_TYPE_HI: begin
          match_nxt = ({b, tlo_r} == target_type);
          phase_nxt = PH_LEN_LO;
        end
        PH_LEN_LO: begin
          len_nxt   = {{ByteBits{1'b0}}, b};
          phase_nxt = PH_LEN_HI;
        end
        PH_LEN_HI: begin
          len_nxt = len_full;
          if (len_full == '0) begin
            phase_nxt = PH_TYPE_LO;
            if (match_r) begin
              res.status  = ST_EMPTY;
              res.is_last = 1'b1;
              res_v       = 1'b1;
              fin         = 1'b1;
              done_nxt    = 1'b1;
            end
          end else begin
            rem_nxt   = len_full;
            phase_nxt = PH_VALUE;
          end
        end
        PH_VALUE: begin
          rem_nxt = rem_dec;
          if (match_r) begin
            res.value_byte    = b;
            res.value_offset  = off;
            res.record_length = len_r;
            res_v             = 1'b1;
            if (rem_dec == '0) begin
              res.status  = ST_VALUE;
              res.is_last = 1'b1;
              fin         = 1'b1;
              done_nxt    = 1'b1;
            end else if (eom) begin
              res.status  = ST_TRUNC;
              res.is_last = 1'b1;
              fin         = 1'b1;
            end else begin
              res.status  = ST_VALUE;
              res.is_last = 1'b0;
            end
          end
          if (rem_dec == '0) begin
            phase_nxt = PH_TYPE_LO;
          end
        end
        default: begin
          tlo_nxt   = b;
          phase_nxt = PH_TYPE_HI;
        end
      endcase

      if (eom && !fin) begin
        res         = '0;
        res.status  = match_nxt ? ST_TRUNC : ST_NOTFOUND;
        res.is_last = 1'b1;
        res_v       = 1'b1;
      end
    end

    // drop all search state at message end
    if (eom) begin
      phase_nxt = PH_TYPE_LO;
      tlo_nxt   = '0;
      len_nxt   = '0;
      rem_nxt   = '0;
      match_nxt = 1'b0;
      done_nxt  = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_TYPE_LO;
      tlo_r       <= '0;
      len_r       <= '0;
      rem_r       <= '0;
      match_r     <= 1'b0;
      done_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (fire) begin
        phase_r <= phase_nxt;
        tlo_r   <= tlo_nxt;
        len_r   <= len_nxt;
        rem_r   <= rem_nxt;
        match_r <= match_nxt;
        done_r  <= done_nxt;
      end
      if (take) begin
        out_valid_r <= fire && res_v;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      out_r <= res;
    end
  end

  a_done_silent: assert property (@(posedge clk) disable iff (!rst_n)
    fire && done_r |=> !out_valid_r)
    else $error("result produced after completed match");

  a_notlast_value: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_r.is_last |-> out_r.status == ST_VALUE)
    else $error("non-final result with a status code");

  a_eom_clears: assert property (@(posedge clk) disable iff (!rst_n)
    fire && s1_beat.end_of_message |=> phase_r == PH_TYPE_LO && !done_r && !match_r)
    else $error("search state kept past message end");

  a_value_rem: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_VALUE |-> rem_r != '0)
    else $error("value phase with no bytes remaining");

endmodule

// File: src/tlv_record_finder.sv
// TLV record finder top level: one byte beat in, at most one result beat out per byte.
// A byte is registered in the input stage, and its result in the parser's result register, before it reaches out_ch.
// Throughput: one byte per cycle while out_ch accepts results; the header/value walk is a single registered step.
// Reset (rst_n low, synchronous): search state cleared, target_type set to zero.
// Depends on tlvf_pkg, tlvf_ifs, tlvf_in_stage and tlvf_parser.

module tlv_record_finder import tlvf_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  tlvf_in_if.sink     in_ch,
  tlvf_out_if.source  out_ch,
  tlvf_cfg_if.sink    cfg_ch
);

  logic [LenBits-1:0] target_r;
  in_beat_t           in_beat;
  logic               s1_valid;
  logic               s1_ready;
  in_beat_t           s1_beat;
  out_beat_t          out_beat;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      target_r <= '0;
    end else if (cfg_ch.valid) begin
      target_r <= cfg_ch.target_type;
    end
  end

  assign in_beat.data_byte      = in_ch.data_byte;
  assign in_beat.end_of_message = in_ch.end_of_message;

  tlvf_in_stage u_in_stage (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .in_beat  (in_beat),
    .s1_valid (s1_valid),
    .s1_ready (s1_ready),
    .s1_beat  (s1_beat)
  );

  tlvf_parser u_parser (
    .clk         (clk),
    .rst_n       (rst_n),
    .target_type (target_r),
    .s1_valid    (s1_valid),
    .s1_ready    (s1_ready),
    .s1_beat     (s1_beat),
    .out_valid   (out_ch.valid),
    .out_ready   (out_ch.ready),
    .out_beat    (out_beat)
  );

  assign out_ch.value_byte    = out_beat.value_byte;
  assign out_ch.value_offset  = out_beat.value_offset;
  assign out_ch.record_length = out_beat.record_length;
  assign out_ch.status        = out_beat.status;
  assign out_ch.is_last       = out_beat.is_last;

endmodule

// File: test/tlvf_search_checker.sv
// Checker for the TLV record finder: watches the byte, result and config channels,
// predicts the result beats of each search and compares them field by field.
// Depends on tlvf_pkg and the channel interfaces in tlvf_ifs.

module tlvf_search_checker import tlvf_pkg::*; (
  input  logic   clk,
  input  logic   rst_n,
  tlvf_in_if     in_ch,
  tlvf_out_if    out_ch,
  tlvf_cfg_if    cfg_ch,
  output int     fail_count,
  output int     waiting,
  output int     parsed_bytes,
  output int     status_seen [4]
);

  logic [LenBits-1:0]  target_q;
  phase_t              walk_phase;
  logic [ByteBits-1:0] type_lo_q;
  logic [LenBits-1:0]  length_q;
  logic [LenBits-1:0]  left_q;
  logic                hit_q;
  logic                done_q;

  out_beat_t due_results [$];
  int        fails;
  int        parsed;
  int        by_status [4];

  initial begin
    fail_count  = 0;
    waiting     = 0;
    parsed_bytes = 0;
    status_seen = '{0, 0, 0, 0};
    fails       = 0;
    parsed      = 0;
    by_status   = '{0, 0, 0, 0};
  end

  function automatic void clear_walk();
    walk_phase = PH_TYPE_LO;
    type_lo_q  = '0;
    length_q   = '0;
    left_q     = '0;
    hit_q      = 1'b0;
    done_q     = 1'b0;
  endfunction

  function automatic void walk_record_byte(input logic [ByteBits-1:0] b, input logic eom);
    out_beat_t          r;
    logic               emit;
    logic               closed;
    logic [LenBits-1:0] off;
    r      = '0;
    emit   = 1'b0;
    closed = 1'b0;
    if (!done_q) begin
      case (walk_phase)
        PH_TYPE_HI: begin
          hit_q      = ({b, type_lo_q} == target_q);
          walk_phase = PH_LEN_LO;
        end
        PH_LEN_LO: begin
          length_q   = {8'h00, b};
          walk_phase = PH_LEN_HI;
        end
        PH_LEN_HI: begin
          length_q = {b, length_q[ByteBits-1:0]};
          if (length_q == '0) begin
            walk_phase = PH_TYPE_LO;
            if (hit_q) begin
              r.status  = ST_EMPTY;
              r.is_last = 1'b1;
              emit      = 1'b1;
              closed    = 1'b1;
              done_q    = 1'b1;
            end
          end else begin
            left_q     = length_q;
            walk_phase = PH_VALUE;
          end
        end
        PH_VALUE: begin
          off    = length_q - left_q;
          left_q = left_q - LenBits'(1);
          if (hit_q) begin
            r.value_byte    = b;
            r.value_offset  = off;
            r.record_length = length_q;
            r.status        = ST_VALUE;
            emit            = 1'b1;
            if (left_q == '0) begin
              r.is_last = 1'b1;
              closed    = 1'b1;
              done_q    = 1'b1;
            end else if (eom) begin
              r.status  = ST_TRUNC;
              r.is_last = 1'b1;
              closed    = 1'b1;
            end
          end
          if (left_q == '0) walk_phase = PH_TYPE_LO;
        end
        default: begin
          type_lo_q  = b;
          walk_phase = PH_TYPE_HI;
        end
      endcase
      if (eom && !closed) begin
        r         = '0;
        r.status  = hit_q ? ST_TRUNC : ST_NOTFOUND;
        r.is_last = 1'b1;
        emit      = 1'b1;
      end
    end
    if (emit) due_results.push_back(r);
    if (eom) clear_walk();
  endfunction

  task automatic check_result_beat();
    out_beat_t want;
    if (due_results.size() == 0) begin
      $error("result beat with nothing expected: status %0d value_byte %0h",
             out_ch.status, out_ch.value_byte);
      fails++;
      return;
    end
    want = due_results.pop_front();
    by_status[want.status]++;
    if (out_ch.value_byte !== want.value_byte) begin
      $error("value_byte: expected %0h, got %0h", want.value_byte, out_ch.value_byte);
      fails++;
    end
    if (out_ch.value_offset !== want.value_offset) begin
      $error("value_offset: expected %0h, got %0h", want.value_offset, out_ch.value_offset);
      fails++;
    end
    if (out_ch.record_length !== want.record_length) begin
      $error("record_length: expected %0h, got %0h", want.record_length,
             out_ch.record_length);
      fails++;
    end
    if (out_ch.status !== want.status) begin
      $error("status: expected %0d, got %0d", want.status, out_ch.status);
      fails++;
    end
    if (out_ch.is_last !== want.is_last) begin
      $error("is_last: expected %0b, got %0b", want.is_last, out_ch.is_last);
      fails++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      clear_walk();
      target_q = '0;
      due_results.delete();
    end else begin
      if (cfg_ch.valid && cfg_ch.ready) target_q = cfg_ch.target_type;
      if (in_ch.valid && in_ch.ready) begin
        parsed++;
        walk_record_byte(in_ch.data_byte, in_ch.end_of_message);
      end
      if (out_ch.valid && out_ch.ready) check_result_beat();
    end
    fail_count   <= fails;
    waiting      <= due_results.size();
    parsed_bytes <= parsed;
    status_seen  <= by_status;
  end

endmodule

// File: test/tlv_record_finder_test.sv
// Testbench top for the TLV record finder: clock, reset, byte and config stimulus,
// result back-pressure, watchdog and verdict. Depends on tlvf_pkg, tlvf_ifs,
// tlv_record_finder and tlvf_search_checker.

module tlv_record_finder_test import tlvf_pkg::*; ();

  localparam int QuietLimit  = 4000;
  localparam int DrainCycles = 8;
  localparam int PhaseBytes  = 200;

  // bit 8 marks end of message
  localparam logic [8:0] OPENING [22] = '{
    9'h0FF, 9'h0FF, 9'h002, 9'h000, 9'h000, 9'h1FF,
    9'h180,
    9'h0FF, 9'h0FF, 9'h103,
    9'h0FF, 9'h0FF, 9'h0FF, 9'h0FF, 9'h011, 9'h122,
    9'h0FF, 9'h0FF, 9'h001, 9'h000, 9'h0AB, 9'h155
  };

  localparam logic [LenBits-1:0] TARGETS [8] = '{
    16'h0000, 16'hFFFF, 16'h1234, 16'h00FF, 16'hFF00, 16'hA5C3, 16'h8001, 16'h7FFE
  };

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  tlvf_in_if  in_bus ();
  tlvf_out_if out_bus ();
  tlvf_cfg_if cfg_bus ();

  int fail_count;
  int waiting;
  int parsed_bytes;
  int status_seen [4];

  int          settings_used = 0;
  int          quiet_cycles  = 0;
  bit          src_calm      = 1'b0;
  bit          sink_calm     = 1'b0;
  logic [7:0]  msg_bytes [$];

  tlv_record_finder dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_bus),
    .out_ch (out_bus),
    .cfg_ch (cfg_bus)
  );

  tlvf_search_checker checker_i (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_ch        (in_bus),
    .out_ch       (out_bus),
    .cfg_ch       (cfg_bus),
    .fail_count   (fail_count),
    .waiting      (waiting),
    .parsed_bytes (parsed_bytes),
    .status_seen  (status_seen)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic int pick_gap(input bit calm);
    int roll;
    if (calm) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  task automatic send_byte(input logic [7:0] b, input logic eom);
    int gap;
    gap = pick_gap(src_calm);
    if (gap > 0) begin
      in_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_bus.valid          <= 1'b1;
    in_bus.data_byte      <= b;
    in_bus.end_of_message <= eom;
    do @(posedge clk); while (!in_bus.ready);
  endtask

  task automatic set_target(input logic [LenBits-1:0] t);
    in_bus.valid <= 1'b0;
    do @(posedge clk); while (waiting != 0);
    repeat (DrainCycles) @(posedge clk);
    cfg_bus.valid       <= 1'b1;
    cfg_bus.target_type <= t;
    do @(posedge clk); while (!cfg_bus.ready);
    cfg_bus.valid <= 1'b0;
    settings_used++;
  endtask

  function automatic void build_message(input logic [LenBits-1:0] tgt);
    int shape;
    int nrec;
    int len;
    int keep;
    logic [LenBits-1:0] kind;
    msg_bytes.delete();
    shape = $urandom_range(0, 19);
    if (shape < 2) begin
      repeat ($urandom_range(1, 12)) msg_bytes.push_back(8'($urandom));
      return;
    end
    nrec = $urandom_range(1, 4);
    for (int r = 0; r < nrec; r++) begin
      case ($urandom_range(0, 5))
        0, 1:    kind = tgt;
        2:       kind = tgt ^ (16'h0001 << $urandom_range(0, 15));
        default: kind = 16'($urandom);
      endcase
      case ($urandom_range(0, 19))
        0, 1, 2:    len = 0;
        16, 17, 18: len = $urandom_range(7, 40);
        19:         len = $urandom_range(41, 65535);
        default:    len = $urandom_range(1, 6);
      endcase
      msg_bytes.push_back(kind[7:0]);
      msg_bytes.push_back(kind[15:8]);
      msg_bytes.push_back(8'(len));
      msg_bytes.push_back(8'(len >> 8));
      if (len > 40) begin
        repeat ($urandom_range(0, 5)) msg_bytes.push_back(8'($urandom));
        return;
      end
      repeat (len) msg_bytes.push_back(8'($urandom));
    end
    if (shape >= 17) begin
      keep = $urandom_range(1, msg_bytes.size());
      while (msg_bytes.size() > keep) void'(msg_bytes.pop_back());
    end else if (shape >= 15) begin
      repeat ($urandom_range(1, 8)) msg_bytes.push_back(8'($urandom));
    end
  endfunction

  task automatic send_message();
    if ($urandom_range(0, 5) == 0) src_calm = !src_calm;
    for (int i = 0; i < msg_bytes.size(); i++)
      send_byte(msg_bytes[i], i == msg_bytes.size() - 1);
  endtask

  initial begin
    out_bus.ready = 1'b0;
    forever begin : sink_side
      int hold;
      hold = 0;
      forever begin
        @(posedge clk);
        if ($urandom_range(0, 199) == 0) sink_calm = !sink_calm;
        if (hold > 0) begin
          out_bus.ready <= 1'b0;
          hold--;
        end else begin
          out_bus.ready <= 1'b1;
          hold = pick_gap(sink_calm);
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready) ||
        (cfg_bus.valid && cfg_bus.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == QuietLimit) begin
      $display("end of test: mismatches");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    int phase_start;
    logic [LenBits-1:0] tgt;
    in_bus.valid          = 1'b0;
    in_bus.data_byte      = '0;
    in_bus.end_of_message = 1'b0;
    cfg_bus.valid         = 1'b0;
    cfg_bus.target_type   = '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // empty match against the reset target
    for (int i = 0; i < 4; i++) send_byte(8'h00, i == 3);

    set_target(16'hFFFF);
    for (int i = 0; i < 22; i++) send_byte(OPENING[i][7:0], OPENING[i][8]);

    for (int p = 0; p < 8; p++) begin
      tgt = (p == 2 || p == 5) ? 16'($urandom) : TARGETS[p];
      set_target(tgt);
      phase_start = parsed_bytes;
      while (parsed_bytes - phase_start < PhaseBytes) begin
        build_message(tgt);
        send_message();
      end
    end

    in_bus.valid <= 1'b0;
    do @(posedge clk); while (waiting != 0);
    repeat (DrainCycles) @(posedge clk);

    $display("%0d bytes parsed under %0d target settings, %0d results checked",
             parsed_bytes, settings_used + 1,
             status_seen[0] + status_seen[1] + status_seen[2] + status_seen[3]);
    $display("results by status: value %0d, empty %0d, not found %0d, truncated %0d",
             status_seen[ST_VALUE], status_seen[ST_EMPTY], status_seen[ST_NOTFOUND],
             status_seen[ST_TRUNC]);
    if (fail_count == 0 && waiting == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

// File: filelist.f
src/tlvf_pkg.sv
src/tlvf_ifs.sv
src/tlvf_in_stage.sv
src/tlvf_parser.sv
src/tlv_record_finder.sv
test/tlvf_search_checker.sv
test/tlv_record_finder_test.sv
